>>> design/ssdd_pkg.sv
// Package: constants, font tables and glyph lookup for the scrolling segment display driver.
package ssdd_pkg;

    localparam int unsigned CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_MESSAGE_LENGTH  = 3'd0,
        REG_SCROLL_DELAY_MS = 3'd1,
        REG_DIGIT_SWITCH_MS = 3'd2,
        REG_RENDER_ENABLE   = 3'd3,
        REG_COMMON_ANODE    = 3'd4,
        REG_FONT_SELECT     = 3'd5
    } reg_idx_t;

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_LOAD = 1'b1;

    localparam logic [7:0] GLYPH_FIRST = 8'h21;
    localparam logic [7:0] GLYPH_LAST  = 8'h7E;

    localparam logic [15:0] FONT16 [0:93] = '{
        16'h000C, 16'h0204, 16'hAA3C, 16'hAABB, 16'hEE99, 16'h9371, 16'h0200, 16'h1400,
        16'h4100, 16'hFF00, 16'hAA00, 16'h4000, 16'h8800, 16'h1000, 16'h4400,
        16'h44FF, 16'h040C, 16'h8877, 16'h083F, 16'h888C, 16'h90B3, 16'h88FB, 16'h000F,
        16'h88FF, 16'h88BF,
        16'h2200, 16'h4200, 16'h9400, 16'h8830, 16'h4900, 16'h2807, 16'h0AF7,
        16'h88CF, 16'h2A3F, 16'h00F3, 16'h223F, 16'h80F3, 16'h80C3, 16'h08FB, 16'h88CC,
        16'h2233, 16'h007C, 16'h94C0, 16'h00F0, 16'h05CC, 16'h11CC, 16'h00FF, 16'h88C7,
        16'h10FF, 16'h98C7, 16'h88BB, 16'h2203, 16'h00FC, 16'h44C0, 16'h50CC, 16'h5500,
        16'h88BC, 16'h4433,
        16'h2212, 16'h1100, 16'h2221, 16'h5000, 16'h0030, 16'h0100,
        16'hA070, 16'hA0E0, 16'h8060, 16'h281C, 16'hC060, 16'hAA02, 16'hA2A1, 16'hA0C0,
        16'h2000, 16'h2260, 16'h3600, 16'h00C0, 16'hA848, 16'hA040, 16'hA060, 16'h82C1,
        16'hA281, 16'h8040, 16'hA0A1, 16'h80E0, 16'h2060, 16'h4040, 16'h5048, 16'h5500,
        16'h0A1C, 16'hC020,
        16'hA212, 16'h2200, 16'h2A21, 16'hCC00
    };

    localparam logic [15:0] FONT14 [0:93] = '{
        16'h4006, 16'h0202, 16'h12CE, 16'h12ED, 16'h3FE4, 16'h2359, 16'h0200, 16'h2400,
        16'h0900, 16'h3FC0, 16'h12C0, 16'h0800, 16'h00C0, 16'h4000, 16'h0C00,
        16'h0C3F, 16'h0406, 16'h00DB, 16'h008F, 16'h00E6, 16'h2069, 16'h00FD, 16'h0007,
        16'h00FF, 16'h00EF,
        16'h1200, 16'h0A00, 16'h2440, 16'h00C8, 16'h0980, 16'h5083, 16'h02BB,
        16'h00F7, 16'h128F, 16'h0039, 16'h120F, 16'h0079, 16'h0071, 16'h00BD, 16'h00F6,
        16'h1209, 16'h001E, 16'h2470, 16'h0038, 16'h0536, 16'h2136, 16'h003F, 16'h00F3,
        16'h203F, 16'h20F3, 16'h00ED, 16'h1201, 16'h003E, 16'h0C30, 16'h2836, 16'h2D00,
        16'h00EE, 16'h0C09,
        16'h0039, 16'h2100, 16'h000F, 16'h2800, 16'h0008, 16'h0100,
        16'h1058, 16'h2078, 16'h00D8, 16'h088E, 16'h0858, 16'h14C0, 16'h048E, 16'h1070,
        16'h1000, 16'h0A10, 16'h3600, 16'h0030, 16'h10D4, 16'h1050, 16'h00DC, 16'h0170,
        16'h0486, 16'h0050, 16'h2088, 16'h0078, 16'h001C, 16'h0810, 16'h2814, 16'h2D00,
        16'h028E, 16'h0848,
        16'h0949, 16'h1200, 16'h2489, 16'h0CC0
    };

    function automatic logic [15:0] glyph(input logic [7:0] code, input logic font14,
                                          input logic invert);
        logic [15:0] pat;
        logic [6:0]  k;
        pat = 16'h0000;
        k   = 7'(code - GLYPH_FIRST);
        if (code >= GLYPH_FIRST && code <= GLYPH_LAST) begin
            pat = font14 ? FONT14[k] : FONT16[k];
        end
        glyph = invert ? ~pat : pat;
    endfunction

endpackage

>>> design/scrolling_segment_display_driver_unit.sv
// Top level: scrolling two-digit 16/14-segment display driver with stream ports and APB registers.
//
// One input transfer is taken every cycle unless s_tready is low. A transfer passes into an
// input register; its message store access, switch timing, scroll step and font lookup are
// resolved from that register when the output register can take a result, and the result
// lands in the output register, which drives m_tvalid. Latency is set by the two register stages;
// throughput by the output register, which holds while m_tready is low and stalls the input
// only when both stages are full. Loads, ticks that cause no switch and ticks while rendering
// is disabled produce no output transfer.
module scrolling_segment_display_driver_unit #(
    parameter int unsigned MESSAGE_DEPTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            s_tuser,   // action
    input  logic [47:0]                     s_tdata,   // now_ms, char_index, char_code, zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // segment_pattern, left/right_common_level, pad
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ssdd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import ssdd_pkg::*;

    localparam int unsigned IDX_W = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
    localparam int unsigned LEN_W = $clog2(MESSAGE_DEPTH + 1);

    logic [5:0]  msg_len_reg;
    logic [15:0] scroll_delay_reg;
    logic [7:0]  switch_ms_reg;
    logic        render_en_reg;
    logic        anode_reg;
    logic        font_sel_reg;

    logic [7:0]  store_reg [MESSAGE_DEPTH];

    logic [IDX_W-1:0] offset_reg, offset_next;
    logic [31:0] last_switch_reg, last_scroll_reg;
    logic        left_reg;

    logic        in_valid_reg;
    logic        in_action_reg;
    logic [31:0] in_now_reg;
    logic [4:0]  in_idx_reg;
    logic [7:0]  in_code_reg;

    logic        out_valid_reg;
    logic [17:0] out_data_reg;

    logic        stage_go;
    logic        cfg_wr;
    logic [2:0]  cfg_sel;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_sel  = paddr[4:2];
    assign stage_go = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || stage_go;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

    always_comb begin
        case (cfg_sel)
            REG_MESSAGE_LENGTH:  prdata = {26'd0, msg_len_reg};
            REG_SCROLL_DELAY_MS: prdata = {16'd0, scroll_delay_reg};
            REG_DIGIT_SWITCH_MS: prdata = {24'd0, switch_ms_reg};
            REG_RENDER_ENABLE:   prdata = {31'd0, render_en_reg};
            REG_COMMON_ANODE:    prdata = {31'd0, anode_reg};
            REG_FONT_SELECT:     prdata = {31'd0, font_sel_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Tick evaluation on the input register
    logic [LEN_W-1:0] len;
    logic             do_switch, do_scroll;
    logic [IDX_W-1:0] base_off, right_off;
    logic [LEN_W:0]   inc_off;
    logic [7:0]       left_ch, right_ch, shown_ch;
    logic             show_left;
    logic             load_hit;

    always_comb begin
        len = (32'(msg_len_reg) > 32'(MESSAGE_DEPTH)) ? LEN_W'(MESSAGE_DEPTH)
                                                       : LEN_W'(msg_len_reg);
        do_switch = (in_now_reg - last_switch_reg) >= {24'd0, switch_ms_reg};
        base_off  = ((LEN_W+1)'(offset_reg) >= (LEN_W+1)'(len)) ? '0 : offset_reg;
        do_scroll = (len > LEN_W'(2)) &&
                    ((in_now_reg - last_scroll_reg) >= {16'd0, scroll_delay_reg});
        inc_off   = (LEN_W+1)'(base_off) + (LEN_W+1)'(1);
        offset_next = offset_reg;
        if (len != '0) begin
            offset_next = base_off;
            if (do_scroll) begin
                offset_next = (inc_off >= (LEN_W+1)'(len)) ? '0 : IDX_W'(inc_off);
            end
        end
        inc_off   = (LEN_W+1)'(offset_next) + (LEN_W+1)'(1);
        right_off = (inc_off >= (LEN_W+1)'(len)) ? '0 : IDX_W'(inc_off);
        left_ch   = (len != '0) ? store_reg[offset_next] : 8'd0;
        right_ch  = (len > LEN_W'(1)) ? store_reg[right_off] : 8'd0;
        show_left = !left_reg;
        shown_ch  = show_left ? left_ch : right_ch;
        load_hit  = ({27'd0, in_idx_reg} < 32'(MESSAGE_DEPTH));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_len_reg      <= 6'd0;
            scroll_delay_reg <= 16'd500;
            switch_ms_reg    <= 8'd5;
            render_en_reg    <= 1'b1;
            anode_reg        <= 1'b1;
            font_sel_reg     <= 1'b0;
            offset_reg       <= '0;
            last_switch_reg  <= 32'd0;
            last_scroll_reg  <= 32'd0;
            left_reg         <= 1'b0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_sel)
                    REG_MESSAGE_LENGTH:  msg_len_reg      <= pwdata[5:0];
                    REG_SCROLL_DELAY_MS: scroll_delay_reg <= pwdata[15:0];
                    REG_DIGIT_SWITCH_MS: switch_ms_reg    <= pwdata[7:0];
                    REG_RENDER_ENABLE:   render_en_reg    <= pwdata[0];
                    REG_COMMON_ANODE:    anode_reg        <= pwdata[0];
                    REG_FONT_SELECT:     font_sel_reg     <= pwdata[0];
                    default:             ;
                endcase
            end
            if (stage_go) begin
                out_valid_reg <= in_valid_reg && in_action_reg == ACTION_TICK && do_switch &&
                                 render_en_reg;
            end
            if (in_valid_reg && stage_go) begin
                if (in_action_reg == ACTION_LOAD) begin
                    offset_reg <= '0;
                end else if (do_switch) begin
                    left_reg        <= show_left;
                    last_switch_reg <= in_now_reg;
                    offset_reg      <= offset_next;
                    if (do_scroll) begin
                        last_scroll_reg <= in_now_reg;
                    end
                end
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_now_reg    <= s_tdata[31:0];
            in_idx_reg    <= s_tdata[36:32];
            in_code_reg   <= s_tdata[44:37];
        end
        if (in_valid_reg && stage_go && in_action_reg == ACTION_LOAD && load_hit) begin
            store_reg[IDX_W'(in_idx_reg)] <= in_code_reg;
        end
        if (in_valid_reg && stage_go && in_action_reg == ACTION_TICK && do_switch) begin
            out_data_reg <= {show_left ? !anode_reg : anode_reg,
                             show_left ? anode_reg : !anode_reg,
                             glyph(shown_ch, font_sel_reg, anode_reg)};
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
    a_no_result_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && stage_go && in_action_reg == ACTION_LOAD |=> !$rose(m_tvalid))
        else $error("load produced a result");
    a_commons_differ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[16] != m_tdata[17])
        else $error("both commons at the same level");
    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(offset_reg) < 32'(MESSAGE_DEPTH))
        else $error("scroll offset out of range");

endmodule
